@@ src/rrtq_pkg.sv @@
// Package for the round-robin thread queue: sizes, opcodes, sequencer states,
// RAM request struct and circular pointer helpers. No dependencies.
`default_nettype none

package rrtq_pkg;

  localparam int QDEPTH = 16;
  localparam int ADDR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W  = $clog2(QDEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int ID_W   = 16;
  localparam int OP_W   = 2;
  localparam int QLEN_W = 5;

  localparam logic [OP_W-1:0] OP_ADMIT  = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_POP    = 2'd2;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ID_W-1:0]   id_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_SCAN,
    ST_SHIFT
  } state_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    id_t   wdata;
    addr_t raddr;
  } ram_req_t;

  function automatic addr_t ptr_inc(input addr_t p);
    return (p == addr_t'(QDEPTH - 1)) ? '0 : addr_t'(p + 1'b1);
  endfunction

  function automatic addr_t ptr_dec(input addr_t p);
    return (p == '0) ? addr_t'(QDEPTH - 1) : addr_t'(p - 1'b1);
  endfunction

  // head + offset, wrapped once (offset never exceeds the depth)
  function automatic addr_t ptr_add(input addr_t h, input cnt_t c);
    logic [SUM_W-1:0] s;
    s = SUM_W'(h) + SUM_W'(c);
    if (s >= SUM_W'(QDEPTH)) begin
      s = s - SUM_W'(QDEPTH);
    end
    return addr_t'(s);
  endfunction

endpackage

`default_nettype wire

@@ src/rrtq_ram.sv @@
// Id store for the thread queue: one write port, one registered read port.
// Depends on rrtq_pkg.
`default_nettype none

module rrtq_ram (
  input  wire               clk,
  input  wire rrtq_pkg::ram_req_t req,
  output rrtq_pkg::id_t     rdata
);
  import rrtq_pkg::*;

  id_t mem [QDEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

`default_nettype wire

@@ src/round_robin_thread_queue_top.sv @@
// Round-robin ready queue of thread ids: sequencer, pointers and result regs.
// Depends on rrtq_pkg and rrtq_ram.
//
// Usage:
//   A request (opcode, thread_id) is taken on a clock edge with start high
//   and busy low. Admit appends at the tail, pop takes the head, remove
//   deletes the first matching id from the head and closes the gap.
//   Each request gives exactly one result: the result ports are valid for
//   the single cycle in which done is high; the receiver cannot stall it.
//   Admit, opcode 3, and pop or remove on an empty queue finish straight
//   from idle; pop passes through ST_POP for the registered RAM read.
//   Remove reads one entry per cycle to find the match, then moves each
//   later entry up one place per cycle (states ST_SCAN, then ST_SHIFT).
//   busy is high while a request is in work; a new request may be given in
//   the cycle done is high. Entries live in a circular buffer.
//   Reset (rst, synchronous) empties the queue; RAM contents are not cleared.
`default_nettype none

module round_robin_thread_queue_top (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       start,
  output logic                      busy,
  input  wire [rrtq_pkg::OP_W-1:0]  opcode,
  input  wire [rrtq_pkg::ID_W-1:0]  thread_id,
  output logic                      done,
  output logic [rrtq_pkg::ID_W-1:0] popped_id,
  output logic                      popped_valid,
  output logic                      admit_accepted,
  output logic                      remove_found,
  output logic [rrtq_pkg::QLEN_W-1:0] queue_length
);
  import rrtq_pkg::*;

  state_t   state, state_next;
  addr_t    head, head_next;
  cnt_t     count, count_next;
  addr_t    cur, cur_next;
  addr_t    idx, idx_next;
  id_t      key, key_next;
  ram_req_t req;
  id_t      rdata;

  logic fin;
  id_t  pop_id_r;
  logic pv_r, acc_r, found_r;

  logic accept;
  logic last;
  logic match;
  addr_t tail;

  rrtq_ram u_ram (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  assign accept = start && (state == ST_IDLE);
  assign last   = (cnt_t'(idx) == cnt_t'(count - 1'b1));
  assign match  = (rdata == key);
  assign tail   = ptr_add(head, count);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (opcode == OP_POP && count != '0) begin
            state_next = ST_POP;
          end else if (opcode == OP_REMOVE && count != '0) begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_POP: state_next = ST_IDLE;
      ST_SCAN: begin
        if (last) begin
          state_next = ST_IDLE;
        end else if (match) begin
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs: busy and RAM port
  always_comb begin
    busy      = (state != ST_IDLE);
    req.we    = 1'b0;
    req.waddr = tail;
    req.wdata = thread_id;
    req.raddr = head;
    case (state)
      ST_IDLE: begin
        req.we = start && (opcode == OP_ADMIT) && (count != cnt_t'(QDEPTH));
      end
      ST_SCAN: begin
        req.raddr = ptr_inc(cur);
      end
      ST_SHIFT: begin
        req.raddr = ptr_inc(cur);
        req.we    = 1'b1;
        req.waddr = ptr_dec(cur);
        req.wdata = rdata;
      end
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    head_next  = head;
    count_next = count;
    cur_next   = cur;
    idx_next   = idx;
    key_next   = key;
    fin        = 1'b0;
    pop_id_r   = '0;
    pv_r       = 1'b0;
    acc_r      = 1'b0;
    found_r    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          key_next = thread_id;
          cur_next = head;
          idx_next = '0;
          case (opcode)
            OP_ADMIT: begin
              fin = 1'b1;
              if (count != cnt_t'(QDEPTH)) begin
                count_next = cnt_t'(count + 1'b1);
                acc_r      = 1'b1;
              end
            end
            OP_POP, OP_REMOVE: fin = (count == '0);
            default: fin = 1'b1;
          endcase
        end
      end
      ST_POP: begin
        fin        = 1'b1;
        pop_id_r   = rdata;
        pv_r       = 1'b1;
        head_next  = ptr_inc(head);
        count_next = cnt_t'(count - 1'b1);
      end
      ST_SCAN: begin
        if (match && last) begin
          fin        = 1'b1;
          found_r    = 1'b1;
          count_next = cnt_t'(count - 1'b1);
        end else if (last) begin
          fin = 1'b1;
        end else begin
          cur_next = ptr_inc(cur);
          idx_next = addr_t'(idx + 1'b1);
        end
      end
      ST_SHIFT: begin
        if (last) begin
          fin        = 1'b1;
          found_r    = 1'b1;
          count_next = cnt_t'(count - 1'b1);
        end else begin
          cur_next = ptr_inc(cur);
          idx_next = addr_t'(idx + 1'b1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      done  <= fin;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    idx <= idx_next;
    key <= key_next;
    if (fin) begin
      popped_id      <= pop_id_r;
      popped_valid   <= pv_r;
      admit_accepted <= acc_r;
      remove_found   <= found_r;
      queue_length   <= QLEN_W'(count_next);
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= cnt_t'(QDEPTH))
    else $error("queue count above depth");

  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> $countones({popped_valid, admit_accepted, remove_found}) <= 1)
    else $error("more than one result flag set");

  a_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (done || busy))
    else $error("accepted request neither finished nor in work");

  a_pop_len: assert property (@(posedge clk) disable iff (rst)
    (done && popped_valid) |-> (queue_length == QLEN_W'(count)))
    else $error("reported length differs from queue count");
`endif

endmodule

`default_nettype wire

@@ tb/round_robin_thread_queue_top_tb.sv @@
// Self-checking bench for round_robin_thread_queue_top: a queue-based predictor of the
// ready queue, a bursty request driver and a done-strobe monitor.
// Depends on rrtq_pkg and the RTL under src/.

module round_robin_thread_queue_top_tb;
  import rrtq_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 500;   // cycles with no request taken and no result
  localparam int TAIL_CYCLES = 24;   // longer than a full-depth remove
  localparam int RAND_BLOCKS = 11;
  localparam int BLOCK_LEN = 98;

  typedef struct {
    logic [OP_W-1:0] op;
    id_t id;
    bit drain;                       // hold off until every result is back
  } request_t;

  typedef struct packed {
    id_t popped_id;
    logic popped_valid;
    logic admit_accepted;
    logic remove_found;
    logic [QLEN_W-1:0] queue_length;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [OP_W-1:0] opcode = OP_ADMIT;
  id_t thread_id = '0;
  logic busy;
  logic done;
  id_t popped_id;
  logic popped_valid;
  logic admit_accepted;
  logic remove_found;
  logic [QLEN_W-1:0] queue_length;

  request_t pending[$];
  outcome_t expected_outcomes[$];
  id_t ready_ids[$];                 // predicted queue contents, head first

  int n_sent = 0;
  int n_seen = 0;
  int mismatches = 0;
  int gap_left = 0;
  int burst_left = 4;
  int idle_cycles = 0;
  int n_refused = 0, n_removed = 0, n_remove_miss = 0, n_empty_pop = 0, peak_len = 0;

  round_robin_thread_queue_top dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .thread_id(thread_id),
    .done(done),
    .popped_id(popped_id),
    .popped_valid(popped_valid),
    .admit_accepted(admit_accepted),
    .remove_found(remove_found),
    .queue_length(queue_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one taken request to the predicted queue and records its outcome.
  function automatic void apply_request(input logic [OP_W-1:0] op, input id_t id);
    outcome_t o;
    bit hit;
    o = '0;
    hit = 1'b0;
    case (op)
      OP_ADMIT: begin
        if (ready_ids.size() < QDEPTH) begin
          ready_ids.push_back(id);
          o.admit_accepted = 1'b1;
        end else begin
          n_refused++;
        end
      end
      OP_REMOVE: begin
        for (int i = 0; i < ready_ids.size() && !hit; i++) begin
          if (ready_ids[i] == id) begin
            ready_ids.delete(i);
            hit = 1'b1;
          end
        end
        o.remove_found = hit;
        if (hit) n_removed++;
        else n_remove_miss++;
      end
      OP_POP: begin
        if (ready_ids.size() > 0) begin
          o.popped_id = ready_ids.pop_front();
          o.popped_valid = 1'b1;
        end else begin
          n_empty_pop++;
        end
      end
      default: ;
    endcase
    o.queue_length = QLEN_W'(ready_ids.size());
    if (ready_ids.size() > peak_len) peak_len = ready_ids.size();
    expected_outcomes.push_back(o);
  endfunction

  task automatic queue_request(input logic [OP_W-1:0] op, input id_t id, input bit drain);
    request_t r;
    r.op = op;
    r.id = id;
    r.drain = drain;
    pending.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Driver: a request stays up until taken, then bursts and gaps set the pace.
  always @(posedge clk) begin : drive
    request_t r;
    int in_flight;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_request(opcode, thread_id);
        n_sent++;
      end
      in_flight = n_sent - n_seen - (done ? 1 : 0);
      if (start && busy) begin
        // request not yet taken; keep it on the bus
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending.size() == 0 || (pending[0].drain && in_flight > 0)) begin
        start <= 1'b0;
      end else begin
        r = pending.pop_front();
        start <= 1'b1;
        opcode <= r.op;
        thread_id <= r.id;
        burst_left--;
        if (burst_left <= 0) begin
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 8);
        end
      end
    end
  end

  // Monitor: every done strobe is matched against the oldest prediction.
  always @(posedge clk) begin : monitor
    outcome_t e;
    if (!rst && done) begin
      if (expected_outcomes.size() == 0) begin
        $display("%0t: unexpected result, expected none, got id 0x%0h valid %b len %0d",
                 $time, popped_id, popped_valid, queue_length);
        mismatches++;
      end else begin
        e = expected_outcomes.pop_front();
        check_field("popped_id", 32'(e.popped_id), 32'(popped_id));
        check_field("popped_valid", 32'(e.popped_valid), 32'(popped_valid));
        check_field("admit_accepted", 32'(e.admit_accepted), 32'(admit_accepted));
        check_field("remove_found", 32'(e.remove_found), 32'(remove_found));
        check_field("queue_length", 32'(e.queue_length), 32'(queue_length));
      end
      n_seen <= n_seen + 1;
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("round_robin_thread_queue_top verification failed");
      $finish;
    end
  end

  initial begin
    id_t pool[8];
    int mode, pick, pct;
    id_t id;

    // empty queue: pop, remove and the unused opcode
    queue_request(OP_POP, 16'h0000, 1'b0);
    queue_request(OP_REMOVE, 16'h0000, 1'b0);
    queue_request(OP_UNUSED, 16'hFFFF, 1'b0);
    // fill to depth with extremes and a duplicate, then one refused admit
    queue_request(OP_ADMIT, 16'h0000, 1'b0);
    queue_request(OP_ADMIT, 16'hFFFF, 1'b0);
    queue_request(OP_ADMIT, 16'hA5A5, 1'b0);
    queue_request(OP_ADMIT, 16'h5A5A, 1'b0);
    queue_request(OP_ADMIT, 16'hA5A5, 1'b0);
    for (int k = 0; k < 11; k++) queue_request(OP_ADMIT, id_t'(1) << k, 1'b0);
    queue_request(OP_ADMIT, 16'hBEEF, 1'b0);
    // drop the tail entry, then admit again to see the tail is right
    queue_request(OP_REMOVE, 16'h0400, 1'b0);
    queue_request(OP_ADMIT, 16'h7777, 1'b0);
    queue_request(OP_REMOVE, 16'hA5A5, 1'b0);  // only the copy nearest the head
    queue_request(OP_REMOVE, 16'h1234, 1'b0);
    queue_request(OP_POP, 16'hFFFF, 1'b0);
    queue_request(OP_UNUSED, 16'h8001, 1'b0);

    // random blocks: each leans toward filling, draining or neither, and
    // draws ids mostly from a small pool so removes hit and duplicates occur
    for (int b = 0; b < RAND_BLOCKS; b++) begin
      mode = $urandom_range(0, 2);
      foreach (pool[i]) pool[i] = id_t'($urandom);
      if ($urandom_range(0, 2) == 0) begin
        pool[0] = '0;
        pool[1] = '1;
      end
      for (int n = 0; n < BLOCK_LEN; n++) begin
        pct = $urandom_range(0, 99);
        pick = $urandom_range(0, 4);
        id = (pick == 0) ? id_t'($urandom) : pool[$urandom_range(0, 7)];
        if (pct < 5) begin
          queue_request(OP_UNUSED, id_t'($urandom), 1'b0);
        end else if (pct < ((mode == 0) ? 70 : (mode == 1) ? 30 : 45)) begin
          queue_request(OP_ADMIT, id, n == 0 && b % 4 == 0);
        end else if (pct < ((mode == 0) ? 85 : (mode == 1) ? 60 : 70)) begin
          queue_request(OP_REMOVE, id, n == 0 && b % 4 == 0);
        end else begin
          queue_request(OP_POP, id_t'($urandom), n == 0 && b % 4 == 0);
        end
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (pending.size() != 0 || start || expected_outcomes.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d requests: %0d admits refused at full depth, %0d removes hit, %0d missed",
             n_sent, n_refused, n_removed, n_remove_miss);
    $display("%0d pops on an empty queue, peak queue length %0d", n_empty_pop, peak_len);
    if (mismatches == 0 && expected_outcomes.size() == 0) begin
      $display("round_robin_thread_queue_top verification clean");
    end else begin
      $display("round_robin_thread_queue_top verification failed");
    end
    $finish;
  end

endmodule
